@@ rtl/nba_pkg.sv @@
`default_nettype none

package nba_pkg;

    // Longest text, in characters, that sets the banner width.
    localparam int unsigned MAX_TEXT_CHARS = 255;

    // Banner geometry and timing constants.
    localparam int unsigned CHAR_PX         = 6;
    localparam int unsigned TEXT_PAD_PX     = 40;
    localparam int unsigned EDGE_PX         = 8;
    localparam int unsigned MS_PER_S        = 1000;

    // Serial divider: one quotient bit per cycle over a 32-bit dividend.
    localparam int unsigned DIV_STEPS = 32;
    localparam int unsigned DIV_CNT_W = $clog2(DIV_STEPS);

    // Item operation codes.
    localparam logic OP_TICK  = 1'b0;
    localparam logic OP_START = 1'b1;

    // Configuration register indexes.
    localparam int unsigned CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_SHRINK_TIME   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SHRINK_PX     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SCROLL_SPEED  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_DISPLAY_WIDTH = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_UNSHRINK_TIME = 3'd4;

    // Configuration reset values.
    localparam logic [15:0] SHRINK_TIME_RST   = 16'd300;
    localparam logic [7:0]  SHRINK_PX_RST     = 8'd8;
    localparam logic [11:0] SCROLL_SPEED_RST  = 12'd40;
    localparam logic [11:0] DISPLAY_WIDTH_RST = 12'd128;
    localparam logic [15:0] UNSHRINK_TIME_RST = 16'd300;

    // Banner phase, as it is reported in every result.
    typedef enum logic [1:0] {
        PH_IDLE     = 2'd0,
        PH_SHRINK   = 2'd1,
        PH_SCROLL   = 2'd2,
        PH_UNSHRINK = 2'd3
    } phase_t;

    typedef struct packed {
        logic        operation;
        logic [31:0] now_ms;
        logic [7:0]  text_len;
    } in_item_t;

    typedef struct packed {
        logic [7:0]         shrink_amount;
        logic signed [15:0] scroll_pos;
        logic               text_visible;
        logic               banner_active;
        logic               busy_res;
        logic [1:0]         phase_out;
    } out_item_t;

    // Strobes from the controller to the datapath, one per step.
    typedef struct packed {
        logic load;
        logic elapsed;
        logic eval;
        logic div_step;
        logic quot;
        logic check;
        logic cube2;
        logic cube3;
        logic round;
        logic emit;
    } cmd_t;

    // Status from the datapath that steers the controller.
    typedef struct packed {
        logic   is_start;
        logic   active;
        phase_t phase;
        logic   el_ge;
        logic   out_free;
    } stat_t;

endpackage

`default_nettype wire

@@ rtl/nba_ctrl.sv @@
`default_nettype none

module nba_ctrl
(
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           in_valid,
    output logic                in_stall,
    input  wire nba_pkg::stat_t stat,
    output nba_pkg::cmd_t       cmd
);

    typedef enum logic [9:0] {
        ST_IDLE    = 10'b00_0000_0001,
        ST_ELAPSED = 10'b00_0000_0010,
        ST_EVAL    = 10'b00_0000_0100,
        ST_DIV     = 10'b00_0000_1000,
        ST_QUOT    = 10'b00_0001_0000,
        ST_CHECK   = 10'b00_0010_0000,
        ST_CUBE2   = 10'b00_0100_0000,
        ST_CUBE3   = 10'b00_1000_0000,
        ST_ROUND   = 10'b01_0000_0000,
        ST_WRITE   = 10'b10_0000_0000
    } state_t;

    state_t                          state_reg;
    state_t                          state_next;
    logic [nba_pkg::DIV_CNT_W-1:0]   cnt_reg;
    logic [nba_pkg::DIV_CNT_W-1:0]   cnt_next;

    // A new word is taken only between items.
    assign in_stall = (state_reg != ST_IDLE);

    // Command strobes follow the current step.
    always_comb
    begin
        cmd          = '0;
        cmd.load     = (state_reg == ST_IDLE) && in_valid;
        cmd.elapsed  = (state_reg == ST_ELAPSED);
        cmd.eval     = (state_reg == ST_EVAL);
        cmd.div_step = (state_reg == ST_DIV);
        cmd.quot     = (state_reg == ST_QUOT);
        cmd.check    = (state_reg == ST_CHECK);
        cmd.cube2    = (state_reg == ST_CUBE2);
        cmd.cube3    = (state_reg == ST_CUBE3);
        cmd.round    = (state_reg == ST_ROUND);
        cmd.emit     = (state_reg == ST_WRITE) && stat.out_free;
    end

    // Step sequencing.
    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_ELAPSED;
                end
            end
            ST_ELAPSED:
            begin
                state_next = ST_EVAL;
            end
            ST_EVAL:
            begin
                cnt_next = nba_pkg::DIV_CNT_W'(nba_pkg::DIV_STEPS - 1);
                if (stat.is_start || !stat.active)
                begin
                    state_next = ST_WRITE;
                end
                else
                begin
                    case (stat.phase)
                        nba_pkg::PH_SHRINK:   state_next = stat.el_ge ? ST_WRITE : ST_DIV;
                        nba_pkg::PH_SCROLL:   state_next = ST_DIV;
                        nba_pkg::PH_UNSHRINK: state_next = stat.el_ge ? ST_WRITE : ST_DIV;
                        default:              state_next = ST_WRITE;
                    endcase
                end
            end
            ST_DIV:
            begin
                if (cnt_reg == '0)
                begin
                    state_next = ST_QUOT;
                end
                else
                begin
                    cnt_next = cnt_reg - 1'b1;
                end
            end
            ST_QUOT:
            begin
                case (stat.phase)
                    nba_pkg::PH_SCROLL:   state_next = ST_CHECK;
                    nba_pkg::PH_UNSHRINK: state_next = ST_CUBE2;
                    default:              state_next = ST_WRITE;
                endcase
            end
            ST_CHECK:
            begin
                state_next = ST_WRITE;
            end
            ST_CUBE2:
            begin
                state_next = ST_CUBE3;
            end
            ST_CUBE3:
            begin
                state_next = ST_ROUND;
            end
            ST_ROUND:
            begin
                state_next = ST_WRITE;
            end
            ST_WRITE:
            begin
                if (stat.out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

endmodule

`default_nettype wire

@@ rtl/nba_datapath.sv @@
`default_nettype none

module nba_datapath
(
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire nba_pkg::in_item_t                 in_data,
    input  wire logic                              cfg_valid,
    input  wire logic [nba_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [15:0]                       cfg_data,
    output logic                                   out_valid,
    input  wire logic                              out_stall,
    output nba_pkg::out_item_t                     out_data,
    input  wire nba_pkg::cmd_t                     cmd,
    output nba_pkg::stat_t                         stat
);

    // Configuration registers.
    logic [15:0] shrink_time_reg,   shrink_time_next;
    logic [7:0]  shrink_px_reg,     shrink_px_next;
    logic [11:0] speed_reg,         speed_next;
    logic [11:0] width_reg,         width_next;
    logic [15:0] unshrink_time_reg, unshrink_time_next;

    // Current item.
    logic        op_reg,  op_next;
    logic [31:0] now_reg, now_next;
    logic [7:0]  len_reg, len_next;

    // Banner state.
    nba_pkg::phase_t phase_reg, phase_next;
    logic        active_reg,      active_next;
    logic [31:0] phase_start_reg, phase_start_next;
    logic [31:0] scroll_start_reg, scroll_start_next;
    logic [10:0] text_width_reg,  text_width_next;
    logic [7:0]  shrink_reg,      shrink_next;
    logic [15:0] scroll_reg,      scroll_next;
    logic        visible_reg,     visible_next;

    // Working registers.
    logic [31:0] el_reg,   el_next;
    logic [16:0] rem_reg,  rem_next;
    logic [31:0] quo_reg,  quo_next;
    logic [15:0] dvs_reg,  dvs_next;
    logic [31:0] sq_reg,   sq_next;
    logic [47:0] cube_reg, cube_next;
    logic [56:0] prod_reg, prod_next;

    // Result register.
    logic                out_valid_reg, out_valid_next;
    nba_pkg::out_item_t  out_data_reg,  out_data_next;

    // Combinational helpers.
    logic [7:0]         len_clamp;
    logic [10:0]        tw_calc;
    logic [15:0]        limit;
    logic               el_ge;
    logic [23:0]        shrink_prod;
    logic [31:0]        scroll_prod;
    logic [16:0]        div_trial;
    logic               div_fit;
    logic [15:0]        scroll_calc;
    logic signed [17:0] pos_sum;
    logic [48:0]        ease_rem;
    logic [56:0]        round_sum;
    logic               busy;

    // Text width from the clamped character count.
    assign len_clamp = ({2'b00, len_reg} > 10'(nba_pkg::MAX_TEXT_CHARS))
                     ? 8'(nba_pkg::MAX_TEXT_CHARS) : len_reg;
    assign tw_calc   = (len_clamp == '0) ? '0
                     : 11'({3'b000, len_clamp} * 11'(nba_pkg::CHAR_PX)
                           + 11'(nba_pkg::TEXT_PAD_PX));

    // Phase end test against the duration of the current phase.
    assign limit = (phase_reg == nba_pkg::PH_SHRINK) ? shrink_time_reg : unshrink_time_reg;
    assign el_ge = (el_reg >= {16'h0000, limit});

    // Dividends for the linear shrink and the scroll travel.
    assign shrink_prod = {8'h00, el_reg[15:0]} * {16'h0000, shrink_px_reg};
    assign scroll_prod = el_reg * {20'h00000, speed_reg};

    // One restoring divide step.
    assign div_trial = {rem_reg[15:0], quo_reg[31]};
    assign div_fit   = (div_trial >= {1'b0, dvs_reg});

    // Scroll position and the test for text fully past the left edge.
    assign scroll_calc = {4'h0, width_reg} + 16'(nba_pkg::EDGE_PX) - quo_reg[15:0];
    assign pos_sum     = {{2{scroll_reg[15]}}, scroll_reg} + {7'h00, text_width_reg};

    // Cubic ease-out: (1 - t^3) scaled by the full shrink, rounded.
    assign ease_rem  = {1'b1, 48'h0} - {1'b0, cube_reg};
    assign round_sum = prod_reg + (57'd1 << 47);

    assign busy = active_reg && ((phase_reg != nba_pkg::PH_IDLE) || visible_reg);

    always_comb
    begin
        shrink_time_next   = shrink_time_reg;
        shrink_px_next     = shrink_px_reg;
        speed_next         = speed_reg;
        width_next         = width_reg;
        unshrink_time_next = unshrink_time_reg;
        op_next            = op_reg;
        now_next           = now_reg;
        len_next           = len_reg;
        phase_next         = phase_reg;
        active_next        = active_reg;
        phase_start_next   = phase_start_reg;
        scroll_start_next  = scroll_start_reg;
        text_width_next    = text_width_reg;
        shrink_next        = shrink_reg;
        scroll_next        = scroll_reg;
        visible_next       = visible_reg;
        el_next            = el_reg;
        rem_next           = rem_reg;
        quo_next           = quo_reg;
        dvs_next           = dvs_reg;
        sq_next            = sq_reg;
        cube_next          = cube_reg;
        prod_next          = prod_reg;
        out_valid_next     = out_valid_reg;
        out_data_next      = out_data_reg;

        // Register writes; unknown indexes are dropped.
        if (cfg_valid)
        begin
            case (cfg_index)
                nba_pkg::CFG_SHRINK_TIME:   shrink_time_next   = cfg_data;
                nba_pkg::CFG_SHRINK_PX:     shrink_px_next     = cfg_data[7:0];
                nba_pkg::CFG_SCROLL_SPEED:  speed_next         = cfg_data[11:0];
                nba_pkg::CFG_DISPLAY_WIDTH: width_next         = cfg_data[11:0];
                nba_pkg::CFG_UNSHRINK_TIME: unshrink_time_next = cfg_data;
                default:                    ;
            endcase
        end

        // Capture the incoming word.
        if (cmd.load)
        begin
            op_next  = in_data.operation;
            now_next = in_data.now_ms;
            len_next = in_data.text_len;
        end

        // Time since the reference point of the current phase.
        if (cmd.elapsed)
        begin
            el_next = now_reg - ((phase_reg == nba_pkg::PH_SCROLL)
                                 ? scroll_start_reg : phase_start_reg);
        end

        // Direct updates, or set up the divider.
        if (cmd.eval)
        begin
            if (op_reg == nba_pkg::OP_START)
            begin
                text_width_next  = tw_calc;
                active_next      = (len_clamp != '0);
                phase_next       = nba_pkg::PH_SHRINK;
                phase_start_next = now_reg;
                shrink_next      = '0;
                scroll_next      = '0;
                visible_next     = 1'b0;
            end
            else if (!active_reg)
            begin
                phase_next   = nba_pkg::PH_IDLE;
                shrink_next  = '0;
                scroll_next  = '0;
                visible_next = 1'b0;
            end
            else
            begin
                case (phase_reg)
                    nba_pkg::PH_SHRINK:
                    begin
                        if (el_ge)
                        begin
                            shrink_next       = shrink_px_reg;
                            phase_next        = nba_pkg::PH_SCROLL;
                            scroll_start_next = now_reg;
                        end
                        else
                        begin
                            quo_next = {8'h00, shrink_prod};
                            dvs_next = shrink_time_reg;
                            rem_next = '0;
                        end
                    end
                    nba_pkg::PH_SCROLL:
                    begin
                        quo_next = scroll_prod;
                        dvs_next = 16'(nba_pkg::MS_PER_S);
                        rem_next = '0;
                    end
                    nba_pkg::PH_UNSHRINK:
                    begin
                        if (el_ge)
                        begin
                            shrink_next  = '0;
                            scroll_next  = '0;
                            visible_next = 1'b0;
                            active_next  = 1'b0;
                            phase_next   = nba_pkg::PH_IDLE;
                        end
                        else
                        begin
                            quo_next = {el_reg[15:0], 16'h0000};
                            dvs_next = unshrink_time_reg;
                            rem_next = '0;
                        end
                    end
                    default:
                    begin
                    end
                endcase
            end
        end

        // Quotient bit per cycle, shifted in from the right.
        if (cmd.div_step)
        begin
            rem_next = div_fit ? (div_trial - {1'b0, dvs_reg}) : div_trial;
            quo_next = {quo_reg[30:0], div_fit};
        end

        // Use the quotient.
        if (cmd.quot)
        begin
            case (phase_reg)
                nba_pkg::PH_SHRINK:
                begin
                    shrink_next = quo_reg[7:0];
                end
                nba_pkg::PH_SCROLL:
                begin
                    shrink_next  = shrink_px_reg;
                    visible_next = 1'b1;
                    scroll_next  = scroll_calc;
                end
                nba_pkg::PH_UNSHRINK:
                begin
                    sq_next = {16'h0000, quo_reg[15:0]} * {16'h0000, quo_reg[15:0]};
                end
                default:
                begin
                end
            endcase
        end

        // Text has left the display: start the unshrink.
        if (cmd.check)
        begin
            if (pos_sum < -$signed(18'(nba_pkg::EDGE_PX)))
            begin
                phase_next       = nba_pkg::PH_UNSHRINK;
                phase_start_next = now_reg;
                visible_next     = 1'b0;
            end
        end

        if (cmd.cube2)
        begin
            cube_next = {16'h0000, sq_reg} * {32'h0000_0000, quo_reg[15:0]};
        end

        if (cmd.cube3)
        begin
            prod_next = {8'h00, ease_rem} * {49'h0, shrink_px_reg};
        end

        if (cmd.round)
        begin
            shrink_next = round_sum[55:48];
        end

        // Result register: freed when taken, loaded when the item is done.
        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
        if (cmd.emit)
        begin
            out_valid_next              = 1'b1;
            out_data_next.shrink_amount = shrink_reg;
            out_data_next.scroll_pos    = $signed(scroll_reg);
            out_data_next.text_visible  = visible_reg;
            out_data_next.banner_active = active_reg;
            out_data_next.busy_res      = busy;
            out_data_next.phase_out     = phase_reg;
        end
    end

    // Control state and configuration.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            shrink_time_reg   <= nba_pkg::SHRINK_TIME_RST;
            shrink_px_reg     <= nba_pkg::SHRINK_PX_RST;
            speed_reg         <= nba_pkg::SCROLL_SPEED_RST;
            width_reg         <= nba_pkg::DISPLAY_WIDTH_RST;
            unshrink_time_reg <= nba_pkg::UNSHRINK_TIME_RST;
            phase_reg         <= nba_pkg::PH_IDLE;
            active_reg        <= 1'b0;
            phase_start_reg   <= '0;
            scroll_start_reg  <= '0;
            text_width_reg    <= '0;
            shrink_reg        <= '0;
            scroll_reg        <= '0;
            visible_reg       <= 1'b0;
            out_valid_reg     <= 1'b0;
        end
        else
        begin
            shrink_time_reg   <= shrink_time_next;
            shrink_px_reg     <= shrink_px_next;
            speed_reg         <= speed_next;
            width_reg         <= width_next;
            unshrink_time_reg <= unshrink_time_next;
            phase_reg         <= phase_next;
            active_reg        <= active_next;
            phase_start_reg   <= phase_start_next;
            scroll_start_reg  <= scroll_start_next;
            text_width_reg    <= text_width_next;
            shrink_reg        <= shrink_next;
            scroll_reg        <= scroll_next;
            visible_reg       <= visible_next;
            out_valid_reg     <= out_valid_next;
        end
    end

    // Working values and payload.
    always_ff @(posedge clk)
    begin
        op_reg       <= op_next;
        now_reg      <= now_next;
        len_reg      <= len_next;
        el_reg       <= el_next;
        rem_reg      <= rem_next;
        quo_reg      <= quo_next;
        dvs_reg      <= dvs_next;
        sq_reg       <= sq_next;
        cube_reg     <= cube_next;
        prod_reg     <= prod_next;
        out_data_reg <= out_data_next;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // Status for the controller.
    always_comb
    begin
        stat          = '0;
        stat.is_start = (op_reg == nba_pkg::OP_START);
        stat.active   = active_reg;
        stat.phase    = phase_reg;
        stat.el_ge    = el_ge;
        stat.out_free = !out_valid_reg || !out_stall;
    end

endmodule

`default_nettype wire

@@ rtl/notification_banner_animator_top.sv @@
`default_nettype none

// Scrolling notification banner sequencer. Each input word is a start (with the
// text length) or a millisecond tick, and each gives exactly one result word with
// the shrink amount, text x position, and the visible, active, busy and phase
// flags after that word. One word is handled at a time: a start, an idle tick or
// a tick that ends a phase passes the elapsed, evaluate and write steps; a tick
// that divides adds the serial divider and the quotient step, then the edge
// check in scroll or the registered multiply steps of the cubic ease in unshrink.
// A finished result waits in an output register, and the next word is accepted
// while it waits. Registers are written through the configuration port, which is
// always ready; write them only while no item is in flight.
module notification_banner_animator_top
(
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          in_valid,
    output logic                               in_stall,
    input  wire nba_pkg::in_item_t             in_data,
    output logic                               out_valid,
    input  wire logic                          out_stall,
    output nba_pkg::out_item_t                 out_data,
    input  wire logic                          cfg_valid,
    output logic                               cfg_ready,
    input  wire logic [nba_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [15:0]                   cfg_data
);

    nba_pkg::cmd_t  cmd;
    nba_pkg::stat_t stat;
    logic           cfg_write;

    // Register writes never wait.
    assign cfg_ready = 1'b1;
    assign cfg_write = cfg_valid && cfg_ready;

    nba_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .stat     (stat),
        .cmd      (cmd)
    );

    nba_datapath u_datapath
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_data   (in_data),
        .cfg_valid (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cmd       (cmd),
        .stat      (stat)
    );

endmodule

`default_nettype wire

@@ rtl/nba_checker.sv @@
`default_nettype none

module nba_checker
(
    input wire logic               clk,
    input wire logic               rst_n,
    input wire logic               in_valid,
    input wire logic               in_stall,
    input wire logic               out_valid,
    input wire logic               out_stall,
    input wire nba_pkg::out_item_t out_data
);

    // A stalled result word stays put.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_data))
        else $error("result word changed while stalled");

    // Only one item is in work: an accepted word closes the input.
    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("input open right after an accepted word");

    // A fresh result appears as the block finishes, so the input reopens with it.
    a_open_on_result: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> !in_stall)
        else $error("result appeared while input still closed");

    // A fresh result comes only out of work on an item.
    a_result_from_work: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_stall))
        else $error("result appeared without an item in work");

    // Visible text belongs to an active banner in the scroll phase.
    a_visible_scroll: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.text_visible |->
            out_data.banner_active && (out_data.phase_out == nba_pkg::PH_SCROLL))
        else $error("text visible outside an active scroll");

endmodule

bind notification_banner_animator_top nba_checker u_nba_checker
(
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
);

`default_nettype wire

@@ tb/sv/testbench.sv @@
`timescale 1ns / 100ps

module testbench;

    import nba_pkg::*;

    localparam int CYCLE_LIMIT = 1000000;
    localparam int SEG_WORDS   = 205;
    localparam int SEG_COUNT   = 8;
    localparam int END_CYCLES  = 64;

    // Register indexes past the end of the register list; writes there are dropped.
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_IDX = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_TOP_IDX    = 3'd7;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 in_valid = 1'b0;
    logic                 in_stall;
    in_item_t             in_data = '0;
    logic                 out_valid;
    logic                 out_stall = 1'b0;
    out_item_t            out_data;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [15:0]          cfg_data = '0;

    // Words waiting to be sent, and banner states predicted for accepted words.
    in_item_t  pending_words[$];
    out_item_t predicted_states[$];

    int   mismatch_cnt = 0;
    int   cycle_cnt = 0;
    logic in_taken = 1'b0;
    logic quiet = 1'b0;
    int   in_gap = 0;
    int   out_hold = 0;

    // Register values as seen by the prediction.
    logic [15:0] cur_shrink_time = SHRINK_TIME_RST;
    logic [7:0]  cur_shrink_px = SHRINK_PX_RST;
    logic [11:0] cur_speed = SCROLL_SPEED_RST;
    logic [11:0] cur_width = DISPLAY_WIDTH_RST;
    logic [15:0] cur_unshrink_time = UNSHRINK_TIME_RST;

    // Register values that shape the generated traffic.
    int plan_st = int'(SHRINK_TIME_RST);
    int plan_px = int'(SHRINK_PX_RST);
    int plan_sp = int'(SCROLL_SPEED_RST);
    int plan_dw = int'(DISPLAY_WIDTH_RST);
    int plan_ut = int'(UNSHRINK_TIME_RST);

    // Banner state tracked by the prediction.
    phase_t      bn_phase = PH_IDLE;
    logic        bn_active = 1'b0;
    logic [31:0] bn_phase_t0 = '0;
    logic [31:0] bn_scroll_t0 = '0;
    logic [10:0] bn_text_w = '0;
    logic [7:0]  bn_shrink = '0;
    logic [15:0] bn_xpos = '0;
    logic        bn_visible = 1'b0;

    notification_banner_animator_top u_dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        forever #10 clk = ~clk;
    end

    // Register write, masked to the register width.
    function automatic void apply_reg(logic [CFG_IDX_W-1:0] idx, logic [15:0] val);
        case (idx)
            CFG_SHRINK_TIME:   cur_shrink_time = val;
            CFG_SHRINK_PX:     cur_shrink_px = val[7:0];
            CFG_SCROLL_SPEED:  cur_speed = val[11:0];
            CFG_DISPLAY_WIDTH: cur_width = val[11:0];
            CFG_UNSHRINK_TIME: cur_unshrink_time = val;
            default: ;
        endcase
    endfunction

    function automatic void clear_banner();
        bn_shrink = '0;
        bn_xpos = '0;
        bn_visible = 1'b0;
    endfunction

    // Advances the banner by one word and returns the state that follows it.
    function automatic out_item_t advance_banner(in_item_t w);
        logic [31:0] el;
        logic [31:0] len;
        logic [31:0] travel;
        logic [63:0] tq;
        logic [63:0] cube;
        logic [63:0] ease;
        out_item_t   r;
        el = w.now_ms - bn_phase_t0;
        if (w.operation == OP_START)
        begin
            len = (w.text_len > MAX_TEXT_CHARS) ? MAX_TEXT_CHARS : 32'(w.text_len);
            bn_text_w = (len == 0) ? '0 : 11'(len * CHAR_PX + TEXT_PAD_PX);
            bn_active = (len != 0);
            bn_phase = PH_SHRINK;
            bn_phase_t0 = w.now_ms;
            clear_banner();
        end
        else if (!bn_active)
        begin
            bn_phase = PH_IDLE;
            clear_banner();
        end
        else
        begin
            case (bn_phase)
                PH_SHRINK:
                begin
                    if (el >= 32'(cur_shrink_time))
                    begin
                        bn_shrink = cur_shrink_px;
                        bn_phase = PH_SCROLL;
                        bn_scroll_t0 = w.now_ms;
                    end
                    else
                    begin
                        bn_shrink = 8'((el * 32'(cur_shrink_px)) / 32'(cur_shrink_time));
                    end
                end
                PH_SCROLL:
                begin
                    travel = ((w.now_ms - bn_scroll_t0) * 32'(cur_speed)) / MS_PER_S;
                    bn_shrink = cur_shrink_px;
                    bn_visible = 1'b1;
                    bn_xpos = 16'(32'(cur_width) + EDGE_PX - travel);
                    // The text has fully left the display on the left side.
                    if (int'($signed(bn_xpos)) + int'(bn_text_w) < -int'(EDGE_PX))
                    begin
                        bn_phase = PH_UNSHRINK;
                        bn_phase_t0 = w.now_ms;
                        bn_visible = 1'b0;
                    end
                end
                PH_UNSHRINK:
                begin
                    if (el >= 32'(cur_unshrink_time))
                    begin
                        clear_banner();
                        bn_active = 1'b0;
                        bn_phase = PH_IDLE;
                    end
                    else
                    begin
                        // Cubic ease-out with t in Q0.16, rounded to nearest.
                        tq = ({32'b0, el} << 16) / 64'(cur_unshrink_time);
                        cube = tq * tq * tq;
                        ease = (((64'd1 << 48) - cube) * 64'(cur_shrink_px)
                                + (64'd1 << 47)) >> 48;
                        bn_shrink = ease[7:0];
                    end
                end
                default: ;
            endcase
        end
        r.shrink_amount = bn_shrink;
        r.scroll_pos = bn_xpos;
        r.text_visible = bn_visible;
        r.banner_active = bn_active;
        r.busy_res = bn_active && (bn_phase != PH_IDLE || bn_visible);
        r.phase_out = bn_phase;
        return r;
    endfunction

    function automatic void check_field(string name, logic signed [31:0] want,
                                        logic signed [31:0] got);
        if (got !== want)
        begin
            $error("%s mismatch: expected %0d, actual %0d", name, want, got);
            mismatch_cnt++;
        end
    endfunction

    // Sampling side: accepted words, register writes and result words.
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            in_taken <= 1'b0;
        end
        else
        begin
            out_item_t want;
            cycle_cnt++;
            if (cycle_cnt > CYCLE_LIMIT)
            begin
                $display("*** FAILED ***");
                $finish;
            end
            else
            begin
                in_taken <= in_valid && !in_stall;
                if (cfg_valid && cfg_ready)
                    apply_reg(cfg_index, cfg_data);
                if (in_valid && !in_stall)
                    predicted_states.push_back(advance_banner(in_data));
                if (out_valid && !out_stall)
                begin
                    if (predicted_states.size() == 0)
                    begin
                        $error("result word with no prediction pending");
                        mismatch_cnt++;
                    end
                    else
                    begin
                        want = predicted_states.pop_front();
                        check_field("shrink_amount", 32'(want.shrink_amount),
                                    32'(out_data.shrink_amount));
                        check_field("scroll_pos", 32'(want.scroll_pos),
                                    32'(out_data.scroll_pos));
                        check_field("text_visible", 32'(want.text_visible),
                                    32'(out_data.text_visible));
                        check_field("banner_active", 32'(want.banner_active),
                                    32'(out_data.banner_active));
                        check_field("busy_res", 32'(want.busy_res),
                                    32'(out_data.busy_res));
                        check_field("phase_out", 32'(want.phase_out),
                                    32'(out_data.phase_out));
                    end
                end
            end
        end
    end

    // Word driver: holds a word until it is taken, with random gaps between words outside quiet segments.
    always @(negedge clk)
    begin
        if (rst_n && !(in_valid && !in_taken))
        begin
            if (!quiet && in_gap == 0 && $urandom_range(0, 7) == 0)
                in_gap = $urandom_range(1, 4);
            if (in_gap > 0)
            begin
                in_gap--;
                in_valid <= 1'b0;
            end
            else if (pending_words.size() > 0)
            begin
                in_data <= pending_words.pop_front();
                in_valid <= 1'b1;
            end
            else
            begin
                in_valid <= 1'b0;
            end
        end
    end

    // Result back-pressure in random bursts outside quiet segments.
    always @(negedge clk)
    begin
        if (!quiet && out_hold == 0 && $urandom_range(0, 7) == 0)
            out_hold = $urandom_range(1, 4);
        if (out_hold > 0)
        begin
            out_hold--;
            out_stall <= 1'b1;
        end
        else
        begin
            out_stall <= 1'b0;
        end
    end

    task automatic push_word(logic op, logic [31:0] now, logic [7:0] len);
        in_item_t w;
        w.operation = op;
        w.now_ms = now;
        w.text_len = len;
        pending_words.push_back(w);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [15:0] val);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
    endtask

    task automatic load_settings(logic [15:0] st, logic [15:0] px, logic [15:0] sp,
                                 logic [15:0] dw, logic [15:0] ut);
        write_reg(CFG_SHRINK_TIME, st);
        write_reg(CFG_SHRINK_PX, px);
        write_reg(CFG_SCROLL_SPEED, sp);
        write_reg(CFG_DISPLAY_WIDTH, dw);
        write_reg(CFG_UNSHRINK_TIME, ut);
        @(negedge clk);
        cfg_valid <= 1'b0;
        plan_st = int'(st);
        plan_px = int'(px[7:0]);
        plan_sp = int'(sp[11:0]);
        plan_dw = int'(dw[11:0]);
        plan_ut = int'(ut);
    endtask

    // Waits until every word is sent and every predicted state has come back.
    task automatic drain();
        while (pending_words.size() != 0 || in_valid || predicted_states.size() != 0)
            @(negedge clk);
    endtask

    // Mostly complete banner runs with random lengths and tick spacing,
    // mixed with stray words, restarts and time jumps.
    task automatic gen_traffic(int n_words);
        logic [31:0] t;
        int          made;
        int          len;
        int          tw;
        int          ticks;
        int          step_max;
        longint      dur;
        t = $urandom();
        made = 0;
        while (made < n_words)
        begin
            if ($urandom_range(0, 9) < 2)
            begin
                case ($urandom_range(0, 3))
                    0, 1: push_word(OP_TICK, $urandom(), 8'($urandom_range(0, 255)));
                    2: push_word(OP_START, $urandom(), 8'($urandom_range(0, 255)));
                    default: push_word(OP_TICK, t - $urandom_range(0, 1000), 8'h00);
                endcase
                made++;
            end
            else
            begin
                len = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 255);
                if ($urandom_range(0, 3) == 0)
                    t = $urandom();
                push_word(OP_START, t, 8'(len));
                tw = (len == 0) ? 0 : len * CHAR_PX + TEXT_PAD_PX;
                dur = longint'(plan_st) + longint'(plan_ut)
                      + longint'(plan_dw + 2 * EDGE_PX + tw) * MS_PER_S
                        / ((plan_sp == 0) ? 1 : plan_sp);
                step_max = int'(dur / 12) + 1;
                ticks = $urandom_range(6, 30);
                repeat (ticks)
                begin
                    t = t + $urandom_range(0, step_max);
                    push_word(OP_TICK, t, 8'($urandom_range(0, 255)));
                end
                made += ticks + 1;
            end
        end
    endtask

    initial
    begin
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed words under the reset settings.
        push_word(OP_TICK, 32'h0000_0000, 8'h00);
        push_word(OP_START, 32'hFFFF_FFFF, 8'h00);
        push_word(OP_TICK, 32'h0000_0005, 8'h00);
        // Longest text, with the shrink phase wrapping through zero time.
        push_word(OP_START, 32'hFFFF_FF00, 8'hFF);
        push_word(OP_TICK, 32'hFFFF_FF00, 8'h00);
        push_word(OP_TICK, 32'hFFFF_FF96, 8'h00);
        push_word(OP_TICK, 32'h0000_002C, 8'h00);
        push_word(OP_TICK, 32'h0000_002C, 8'h00);
        push_word(OP_TICK, 32'd1044, 8'h00);
        push_word(OP_TICK, 32'd50044, 8'h00);
        // Unshrink: half way, just before the end, at the end, then inactive.
        push_word(OP_TICK, 32'd50194, 8'h00);
        push_word(OP_TICK, 32'd50343, 8'h00);
        push_word(OP_TICK, 32'd50344, 8'h00);
        push_word(OP_TICK, 32'd50444, 8'h00);
        // Restart during shrink, and a tick whose time runs backwards.
        push_word(OP_START, 32'hAAAA_AAAA, 8'h01);
        push_word(OP_START, 32'h5555_5555, 8'hAA);
        push_word(OP_TICK, 32'h5555_5554, 8'h00);
        // Scroll exit exactly at the edge, then one pixel past it.
        push_word(OP_START, 32'h1234_5678, 8'h55);
        push_word(OP_TICK, 32'h1234_5678 + 32'd299, 8'h00);
        push_word(OP_TICK, 32'h1234_57A4, 8'h00);
        push_word(OP_TICK, 32'h1234_57A4 + 32'd17350, 8'h00);
        push_word(OP_TICK, 32'h1234_57A4 + 32'd17375, 8'h00);
        push_word(OP_TICK, 32'h1234_57A4 + 32'd17376, 8'h00);
        push_word(OP_START, 32'h0000_0000, 8'hFF);
        drain();

        for (int seg = 0; seg < SEG_COUNT; seg++)
        begin
            case (seg)
                0: ;
                1: load_settings(16'd1, 16'd255, 16'd4095, 16'd4095, 16'd1);
                2: load_settings(16'd65535, 16'd0, 16'd1, 16'd1, 16'd65535);
                3:
                begin
                    // Zero durations and a stopped scroll; upper bits must be masked off.
                    write_reg(CFG_UNUSED_IDX, 16'hFFFF);
                    write_reg(CFG_TOP_IDX, 16'h0000);
                    load_settings(16'd0, 16'hFFC8, 16'hF000, 16'hF040, 16'd0);
                end
                default:
                    load_settings(16'($urandom_range(1, 2000)), 16'($urandom_range(0, 255)),
                                  16'($urandom_range(1, 4095)), 16'($urandom_range(1, 4095)),
                                  16'($urandom_range(1, 2000)));
            endcase
            quiet = (seg == 4) || (seg == SEG_COUNT - 1);
            gen_traffic(SEG_WORDS);
            drain();
        end

        repeat (END_CYCLES) @(posedge clk);
        if (mismatch_cnt == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

@@ sim.f @@
rtl/nba_pkg.sv
rtl/nba_ctrl.sv
rtl/nba_datapath.sv
rtl/notification_banner_animator_top.sv
rtl/nba_checker.sv
tb/sv/testbench.sv
